// File: rtl/lep_pkg.sv
// shared types, register indexes and the color wheel for the led effect pixel engine
// used by lep_div and led_effect_pixel_engine; no dependencies
package lep_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SPREAD = 2'd1;
    localparam logic [1:0] CFG_CHANCE = 2'd2;
    localparam logic [1:0] CFG_FADE   = 2'd3;

    // effect modes; bit 1 set selects sparkle
    localparam logic [1:0] MODE_RAINBOW_UP   = 2'd0;
    localparam logic [1:0] MODE_RAINBOW_DOWN = 2'd1;
    localparam logic [1:0] MODE_SPARKLE      = 2'd2;

    // color channel slots, in the order they are faded
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FADE_GO,
        ST_FADE,
        ST_FINISH
    } lep_state_t;

    typedef struct packed {
        logic start;
        logic half;     // 8-bit dividend, half the steps
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // three-segment wheel, returns {red, green, blue}
    function automatic logic [23:0] color_wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            q = p;
        end
        else if (p < 8'd170) begin
            q = p - 8'd85;
        end
        else begin
            q = p - 8'd170;
        end
        t = 8'({2'b00, q} + {1'b0, q, 1'b0});
        if (p < 8'd85) begin
            r = 8'd255 - t;
            g = 8'd0;
            b = t;
        end
        else if (p < 8'd170) begin
            r = 8'd0;
            g = t;
            b = 8'd255 - t;
        end
        else begin
            r = t;
            g = 8'd255 - t;
            b = 8'd0;
        end
        return {r, g, b};
    endfunction

endpackage

// File: rtl/lep_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lep_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/lep_div.sv
// iterative restoring divider, 16-bit dividend by 8-bit divisor, two bits per cycle
// depends on lep_pkg for the request and status structs
module lep_div
    import lep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output div_stat_t   stat,
    output logic [15:0] quotient,
    output logic [7:0]  remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [7:0]  dsr_reg, dsr_next;

    logic [7:0]  rem_a, rem_b;
    logic [15:0] quo_a, quo_b;
    logic [8:0]  part_a, part_b;
    logic        ge_a, ge_b;

    // two dependent restoring steps per cycle
    always_comb
    begin
        part_a = {rem_reg, quo_reg[15]};
        ge_a   = part_a >= {1'b0, dsr_reg};
        rem_a  = ge_a ? 8'(part_a - {1'b0, dsr_reg}) : part_a[7:0];
        quo_a  = {quo_reg[14:0], ge_a};
        part_b = {rem_a, quo_a[15]};
        ge_b   = part_b >= {1'b0, dsr_reg};
        rem_b  = ge_b ? 8'(part_b - {1'b0, dsr_reg}) : part_b[7:0];
        quo_b  = {quo_a[14:0], ge_b};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            rem_next = rem_b;
            quo_next = quo_b;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = 8'd0;
            dsr_next  = divisor;
            quo_next  = req.half ? {dividend[7:0], 8'h00} : dividend;
            cnt_next  = req.half ? 3'd3 : 3'd7;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/led_effect_pixel_engine.sv
// led effect pixel engine: rainbow wheel and sparkle-with-fade over a pixel store
// rainbow item: one full-width division of the led position by the spread, then finish
// sparkle item: a chance division, then a half-width fade division per channel
// both paths use the shared divider (two quotient bits per cycle); no new
// item is taken until the current one leaves the finish step; after reset the pixel
// store is swept to zero, taking no item; control registers reset at once
module led_effect_pixel_engine
    import lep_pkg::*;
#(
    parameter int ROW_COUNT    = 8,
    parameter int LEDS_PER_ROW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_start,
    input  logic [2:0]  row,
    input  logic [4:0]  led,
    input  logic [15:0] random_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red
);

    localparam int DEPTH = ROW_COUNT * LEDS_PER_ROW;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0]  ROW_LIM = 5'(ROW_COUNT);
    localparam logic [8:0]  LED_LIM = 9'(LEDS_PER_ROW);
    localparam logic [11:0] ROW_STEP = 12'(LEDS_PER_ROW);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    lep_state_t state_reg, state_next;

    logic [1:0]    mode_reg;
    logic [7:0]    spread_reg;
    logic [7:0]    chance_reg;
    logic [7:0]    fade_reg;
    logic [7:0]    phase_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic          sparkle_reg;
    logic          inside_reg;
    logic [AW-1:0] addr_reg;
    logic [23:0]   pix_reg;
    logic [1:0]    ch_reg;

    logic          out_valid_reg;
    logic [7:0]    blue_reg, green_reg, red_reg;

    logic [7:0]    spread_eff, chance_eff, fade_eff;
    logic          in_fire, finish_fire, in_inside;
    logic [11:0]   in_addr_full;
    logic [AW-1:0] in_addr;

    div_req_t      div_req;
    div_stat_t     div_stat;
    logic [15:0]   div_dividend;
    logic [7:0]    div_divisor;
    logic [15:0]   div_q;
    logic [7:0]    div_r;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [23:0]   ram_rdata;

    logic [23:0]   old_pix;
    logic [7:0]    fade_in, fade_out;

    assign spread_eff = (spread_reg == 8'd0) ? 8'd1 : spread_reg;
    assign chance_eff = (chance_reg == 8'd0) ? 8'd1 : chance_reg;
    assign fade_eff   = (fade_reg == 8'd0) ? 8'd1 : fade_reg;

    assign in_inside    = ({2'b00, row} < ROW_LIM) && ({4'h0, led} < LED_LIM);
    assign in_addr_full = 12'(row) * ROW_STEP + 12'(led);
    assign in_addr      = in_addr_full[AW-1:0];

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_fire     = in_valid && (state_reg == ST_IDLE);
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // stored color, out-of-store pixels read as black, a hit lights full white
    assign old_pix = (div_r == 8'd0) ? 24'hFFFFFF : (inside_reg ? ram_rdata : 24'h000000);

    always_comb
    begin
        case (ch_reg)
            CH_RED:   fade_in = pix_reg[23:16];
            CH_GREEN: fade_in = pix_reg[15:8];
            default:  fade_in = pix_reg[7:0];
        endcase
    end

    assign fade_out = (fade_in > fade_eff) ? fade_in - div_q[7:0] : 8'd0;

    always_comb
    begin
        state_next   = state_reg;
        div_req      = '0;
        div_dividend = 16'h0000;
        div_divisor  = fade_eff;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_req.start = 1'b1;
                    if (mode_reg[1])
                    begin
                        div_dividend = random_value;
                        div_divisor  = chance_eff;
                    end
                    else
                    begin
                        div_dividend = {3'b000, led, 8'h00};
                        div_divisor  = spread_eff;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = sparkle_reg ? ST_FADE_GO : ST_FINISH;
                end
            end
            ST_FADE_GO:
            begin
                div_req.start = 1'b1;
                div_req.half  = 1'b1;
                div_dividend  = {8'h00, fade_in};
                state_next    = ST_FADE;
            end
            ST_FADE:
            begin
                if (div_stat.done)
                begin
                    state_next = (ch_reg == CH_BLUE) ? ST_FINISH : ST_FADE_GO;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration, phase, clear sweep and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RAINBOW_UP;
            spread_reg    <= 8'd15;
            chance_reg    <= 8'd50;
            fade_reg      <= 8'd40;
            phase_reg     <= 8'd0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    CFG_SPREAD: spread_reg <= cfg_data;
                    CFG_CHANCE: chance_reg <= cfg_data;
                    CFG_FADE:   fade_reg   <= cfg_data;
                    default:    mode_reg   <= mode_reg;
                endcase
            end
            if (in_fire && !mode_reg[1] && frame_start)
            begin
                phase_reg <= (mode_reg == MODE_RAINBOW_UP) ? phase_reg + 8'd1
                                                           : phase_reg - 8'd1;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sparkle_reg <= mode_reg[1];
            inside_reg  <= in_inside;
            addr_reg    <= in_addr;
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            ch_reg <= CH_RED;
            if (sparkle_reg)
            begin
                pix_reg <= old_pix;
            end
            else
            begin
                pix_reg <= color_wheel(div_q[7:0] + phase_reg);
            end
        end
        if (state_reg == ST_FADE && div_stat.done)
        begin
            ch_reg <= ch_reg + 2'd1;
            case (ch_reg)
                CH_RED:   pix_reg[23:16] <= fade_out;
                CH_GREEN: pix_reg[15:8]  <= fade_out;
                default:  pix_reg[7:0]   <= fade_out;
            endcase
        end
        if (finish_fire)
        begin
            red_reg   <= pix_reg[23:16];
            green_reg <= pix_reg[15:8];
            blue_reg  <= pix_reg[7:0];
        end
    end

    assign ram_we    = (state_reg == ST_CLEAR) || (finish_fire && inside_reg);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 24'h000000 : pix_reg;

    lep_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    lep_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_valid = out_valid_reg;
    assign blue      = blue_reg;
    assign green     = green_reg;
    assign red       = red_reg;

    // a new beat on the output only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output beat raised outside finish");

    // an accepted item always starts the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg == ST_DIV) && div_stat.busy)
        else $error("accepted item did not start divider");

    // divider results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV || state_reg == ST_FADE))
        else $error("divider finished in unexpected state");

    // the store is never written back while a division is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> !div_stat.busy)
        else $error("divider busy at write-back");

endmodule

// File: verif/testbench.sv
// self-checking testbench for led_effect_pixel_engine: rainbow wheel and sparkle fade
// keeps its own copy of phase, registers and pixel store; depends on lep_pkg and the rtl
module testbench;
    import lep_pkg::*;

    localparam int          ROWS        = 8;
    localparam int          LEDS        = 32;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        frame_start;
    logic [2:0]  row;
    logic [4:0]  led;
    logic [15:0] random_value;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;

    // predicted engine state
    logic [1:0]  eff_mode;
    logic [7:0]  spread_reg;
    logic [7:0]  chance_reg;
    logic [7:0]  fade_reg;
    logic [7:0]  wheel_phase;
    logic [23:0] pixel_mem [ROWS*LEDS];

    pixel_t expected_pixels [$];
    int     mismatches;
    bit     quiet;

    led_effect_pixel_engine uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_start  (frame_start),
        .row          (row),
        .led          (led),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .blue         (blue),
        .green        (green),
        .red          (red)
    );

    always #5 clk = ~clk;

    // returns {red, green, blue}
    function automatic logic [23:0] wheel_rgb(input int pos);
        int p;
        p = 255 - pos;
        if (p < 85)
        begin
            return {8'(255 - 3 * p), 8'd0, 8'(3 * p)};
        end
        else if (p < 170)
        begin
            p = p - 85;
            return {8'd0, 8'(3 * p), 8'(255 - 3 * p)};
        end
        p = p - 170;
        return {8'(3 * p), 8'(255 - 3 * p), 8'd0};
    endfunction

    function automatic logic [7:0] faded(input int c, input int d);
        return (c > d) ? 8'(c - c / d) : 8'd0;
    endfunction

    function automatic pixel_t next_pixel(input logic fs, input logic [2:0] r,
                                          input logic [4:0] l, input logic [15:0] rnd);
        pixel_t      px;
        logic [23:0] old_rgb;
        logic [23:0] new_rgb;
        int          div;
        int          addr;
        bit          in_store;
        in_store = (int'(r) < ROWS) && (int'(l) < LEDS);
        addr = in_store ? int'(r) * LEDS + int'(l) : 0;
        if (!eff_mode[1])
        begin
            div = (spread_reg == 8'd0) ? 1 : int'(spread_reg);
            if (fs)
            begin
                if (eff_mode == MODE_RAINBOW_UP)
                    wheel_phase = wheel_phase + 8'd1;
                else
                    wheel_phase = wheel_phase - 8'd1;
            end
            new_rgb = wheel_rgb(((int'(l) * 256) / div + int'(wheel_phase)) % 256);
        end
        else
        begin
            div = (chance_reg == 8'd0) ? 1 : int'(chance_reg);
            old_rgb = in_store ? pixel_mem[addr] : 24'd0;
            if (int'(rnd) % div == 0)
                old_rgb = 24'hFFFFFF;
            div = (fade_reg == 8'd0) ? 1 : int'(fade_reg);
            new_rgb = {faded(int'(old_rgb[23:16]), div), faded(int'(old_rgb[15:8]), div),
                       faded(int'(old_rgb[7:0]), div)};
        end
        if (in_store)
            pixel_mem[addr] = new_rgb;
        px.red   = new_rgb[23:16];
        px.green = new_rgb[15:8];
        px.blue  = new_rgb[7:0];
        return px;
    endfunction

    // result side: random stall and compare against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel b=%0d g=%0d r=%0d", blue, green, red);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.blue !== blue || want.green !== green || want.red !== red)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                     want.blue, want.green, want.red, blue, green, red);
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic fs, input logic [2:0] r, input logic [4:0] l,
                              input logic [15:0] rnd);
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        frame_start  <= fs;
        row          <= r;
        led          <= l;
        random_value <= rnd;
        expected_pixels.push_back(next_pixel(fs, r, l, rnd));
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MODE:   eff_mode   = val[1:0];
            CFG_SPREAD: spread_reg = val;
            CFG_CHANCE: chance_reg = val;
            CFG_FADE:   fade_reg   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_divisor();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'($urandom_range(2, 8));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic test_rainbow_directed();
        send_pixel(1'b0, 3'd0, 5'd0, 16'h0000);
        send_pixel(1'b1, 3'd7, 5'd31, 16'hFFFF);
        write_reg(CFG_MODE, {6'd0, MODE_RAINBOW_DOWN});
        send_pixel(1'b1, 3'd0, 5'd5, 16'h1234);
        // phase wraps below zero
        send_pixel(1'b1, 3'd1, 5'd6, 16'h5678);
        write_reg(CFG_MODE, {6'd0, MODE_RAINBOW_UP});
        // and back up past 255
        send_pixel(1'b1, 3'd2, 5'd7, 16'h9ABC);
        write_reg(CFG_SPREAD, 8'd1);
        send_pixel(1'b0, 3'd3, 5'd31, 16'h0001);
        write_reg(CFG_SPREAD, 8'd255);
        send_pixel(1'b0, 3'd3, 5'd31, 16'h8000);
        // zero spread acts as one
        write_reg(CFG_SPREAD, 8'd0);
        send_pixel(1'b1, 3'd4, 5'd17, 16'h00FF);
    endtask

    task automatic test_sparkle_directed();
        write_reg(CFG_MODE, {6'd0, MODE_SPARKLE});
        write_reg(CFG_CHANCE, 8'd0);
        write_reg(CFG_FADE, 8'd40);
        send_pixel(1'b0, 3'd2, 5'd9, 16'd123);
        write_reg(CFG_CHANCE, 8'd255);
        // frame start leaves the phase alone here; pixel only fades
        send_pixel(1'b1, 3'd2, 5'd9, 16'hFFFE);
        send_pixel(1'b0, 3'd2, 5'd9, 16'hFFFF);
        write_reg(CFG_FADE, 8'd255);
        send_pixel(1'b0, 3'd2, 5'd9, 16'hFFFE);
        write_reg(CFG_FADE, 8'd254);
        write_reg(CFG_CHANCE, 8'd0);
        send_pixel(1'b0, 3'd2, 5'd9, 16'd7);
        write_reg(CFG_FADE, 8'd0);
        send_pixel(1'b0, 3'd2, 5'd10, 16'd7);
        write_reg(CFG_FADE, 8'd1);
        write_reg(CFG_CHANCE, 8'd1);
        send_pixel(1'b0, 3'd2, 5'd11, 16'd9);
        // mode 3 falls back to sparkle
        write_reg(CFG_MODE, {6'd0, MODE_UNUSED});
        write_reg(CFG_CHANCE, 8'd2);
        write_reg(CFG_FADE, 8'd40);
        send_pixel(1'b1, 3'd7, 5'd31, 16'd1);
        send_pixel(1'b0, 3'd7, 5'd31, 16'd0);
        send_pixel(1'b0, 3'd7, 5'd31, 16'd3);
        write_reg(CFG_CHANCE, 8'd50);
        send_pixel(1'b0, 3'd0, 5'd0, 16'h8000);
    endtask

    task automatic test_random_effects();
        logic [2:0] r;
        logic [4:0] l;
        logic       fs;
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_MODE, 8'(ph % 4));
            write_reg(CFG_SPREAD, pick_divisor());
            write_reg(CFG_CHANCE, pick_divisor());
            write_reg(CFG_FADE, pick_divisor());
            quiet = (ph == 4);
            for (int n = 0; n < 70; n++)
            begin
                // mostly rows 0 and 1, so sparkle revisits pixels and fades pile up
                r  = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
                l  = 5'($urandom_range(31));
                fs = (ph % 4 == 0) ? ($urandom_range(1) == 0) : ($urandom_range(3) == 0);
                send_pixel(fs, r, l, 16'($urandom_range(16'hFFFF)));
                if (ph == 2 && n == 35)
                    wait_drained();
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_MODE;
        cfg_data     <= 8'd0;
        in_valid     <= 1'b0;
        frame_start  <= 1'b0;
        row          <= 3'd0;
        led          <= 5'd0;
        random_value <= 16'd0;
        mismatches   = 0;
        quiet        = 1'b0;
        eff_mode     = MODE_RAINBOW_UP;
        spread_reg   = 8'd15;
        chance_reg   = 8'd50;
        fade_reg     = 8'd40;
        wheel_phase  = 8'd0;
        foreach (pixel_mem[i])
            pixel_mem[i] = 24'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // let the store clear finish before touching registers
        while (in_stall)
            @(posedge clk);
        test_rainbow_directed();
        test_sparkle_directed();
        test_random_effects();
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("led_effect_pixel_engine: match");
        else
            $display("led_effect_pixel_engine: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("led_effect_pixel_engine: mismatch");
        $finish;
    end

endmodule
